### sv/hbcs_pkg.sv
// shared types, constants and the variant default table of the host-bridge configuration space
package hbcs_pkg;

    localparam int REG_BYTES   = 256;
    localparam int VAR_W       = 3;
    localparam int FUNC_W      = 3;
    localparam int OFF_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int REGION_N    = 13;
    localparam int PAM_HI_N    = 6;

    // chip variants
    localparam logic [VAR_W-1:0] CV_420TX     = 3'd0;
    localparam logic [VAR_W-1:0] CV_430LX     = 3'd1;
    localparam logic [VAR_W-1:0] CV_430NX     = 3'd2;
    localparam logic [VAR_W-1:0] CV_430FX     = 3'd3;
    localparam logic [VAR_W-1:0] CV_430FX_BRD = 3'd4;
    localparam logic [VAR_W-1:0] CV_430HX     = 3'd5;
    localparam logic [VAR_W-1:0] CV_430VX     = 3'd6;
    localparam logic [VAR_W-1:0] CV_RESET     = CV_430FX;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // register offsets
    localparam logic [OFF_W-1:0] OFF_VID_LO  = 8'h00;
    localparam logic [OFF_W-1:0] OFF_VID_HI  = 8'h01;
    localparam logic [OFF_W-1:0] OFF_DID_LO  = 8'h02;
    localparam logic [OFF_W-1:0] OFF_DID_HI  = 8'h03;
    localparam logic [OFF_W-1:0] OFF_CMD_LO  = 8'h04;
    localparam logic [OFF_W-1:0] OFF_CMD_HI  = 8'h05;
    localparam logic [OFF_W-1:0] OFF_STS_LO  = 8'h06;
    localparam logic [OFF_W-1:0] OFF_STS_HI  = 8'h07;
    localparam logic [OFF_W-1:0] OFF_REV     = 8'h08;
    localparam logic [OFF_W-1:0] OFF_CLS_0   = 8'h09;
    localparam logic [OFF_W-1:0] OFF_CLS_1   = 8'h0a;
    localparam logic [OFF_W-1:0] OFF_CLS_2   = 8'h0b;
    localparam logic [OFF_W-1:0] OFF_CLS_3   = 8'h0c;
    localparam logic [OFF_W-1:0] OFF_HDR     = 8'h0e;
    localparam logic [OFF_W-1:0] OFF_RO_LO   = 8'h10;
    localparam logic [OFF_W-1:0] OFF_RO_HI   = 8'h4e;
    localparam logic [OFF_W-1:0] OFF_CACHE   = 8'h52;
    localparam logic [OFF_W-1:0] OFF_PAM0    = 8'h59;
    localparam logic [OFF_W-1:0] OFF_PAM1    = 8'h5a;
    localparam logic [OFF_W-1:0] OFF_PAM6    = 8'h5f;
    localparam logic [OFF_W-1:0] OFF_SMRAM   = 8'h72;

    // write masks and forced bits
    localparam logic [BYTE_W-1:0] MASK_CMD_TX  = 8'h42;
    localparam logic [BYTE_W-1:0] MASK_CMD_FXB = 8'h06;
    localparam logic [BYTE_W-1:0] MASK_CMD_FX  = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_FORCE    = 8'h04;
    localparam logic [BYTE_W-1:0] MASK_CMD_HI  = 8'h01;
    localparam logic [BYTE_W-1:0] STS_BASE     = 8'h02;
    localparam logic [BYTE_W-1:0] STS_FXB      = 8'h22;
    localparam logic [BYTE_W-1:0] MASK_STS_KEEP = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_SMM_FX  = 8'h48;
    localparam logic [BYTE_W-1:0] MASK_SMM_TX  = 8'h20;
    localparam logic [BYTE_W-1:0] FUNC_ABSENT  = 8'hff;

    typedef struct packed {
        logic                mode;
        logic [FUNC_W-1:0]   function_number;
        logic [OFF_W-1:0]    reg_offset;
        logic [BYTE_W-1:0]   write_data;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_data;
        logic                ext_cache_enable;
        logic                shadow_bios;
        logic [REGION_N-1:0] pam_read_internal;
        logic [REGION_N-1:0] pam_write_internal;
        logic                smram_open;
    } t_rsp;

    // request held in the first stage, with the current byte at its offset
    typedef struct packed {
        t_req                req;
        logic [BYTE_W-1:0]   old_byte;
    } t_stage;

    // byte store update
    typedef struct packed {
        logic                en;
        logic [OFF_W-1:0]    addr;
        logic [BYTE_W-1:0]   data;
    } t_wb;

    function automatic logic [BYTE_W-1:0] default_byte(
        input logic [VAR_W-1:0] v,
        input logic [OFF_W-1:0] off
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (off) inside
            8'h00: b = 8'h86;
            8'h01: b = 8'h80;
            8'h02: begin
                unique case (v) inside
                    CV_420TX:                  b = 8'h83;
                    CV_430LX, CV_430NX:        b = 8'ha3;
                    CV_430FX, CV_430FX_BRD:    b = 8'h2d;
                    CV_430HX:                  b = 8'h50;
                    default:                   b = 8'h30;
                endcase
            end
            8'h03: begin
                unique case (v) inside
                    CV_420TX, CV_430LX, CV_430NX:       b = 8'h04;
                    CV_430FX, CV_430FX_BRD, CV_430HX:   b = 8'h12;
                    default:                            b = 8'h70;
                endcase
            end
            8'h04: b = 8'h06;
            8'h07: b = (v == CV_430FX) ? 8'h82 : 8'h02;
            8'h08: begin
                unique case (v) inside
                    CV_420TX, CV_430LX: b = 8'h03;
                    CV_430NX:           b = 8'h10;
                    CV_430FX_BRD:       b = 8'h02;
                    default:            b = 8'h00;
                endcase
            end
            8'h0b: b = 8'h06;
            8'h50: begin
                unique case (v) inside
                    CV_420TX, CV_430LX: b = 8'h80;
                    CV_430NX:           b = 8'ha0;
                    default:            b = 8'h00;
                endcase
            end
            8'h51: b = (v == CV_430HX) ? 8'h20 : 8'h00;
            8'h52: begin
                unique case (v) inside
                    CV_430NX: b = 8'h44;
                    CV_430HX: b = 8'hb5;
                    CV_430VX: b = 8'h42;
                    default:  b = 8'h40;
                endcase
            end
            8'h53: b = (v == CV_430VX) ? 8'h14 : 8'h00;
            8'h56: b = (v >= CV_430HX) ? 8'h52 : 8'h00;
            8'h57: b = (v >= CV_430FX) ? 8'h01 : 8'h31;
            [8'h5a:8'h5f]: b = (v == CV_430HX) ? 8'h44 : 8'h00;
            [8'h60:8'h64]: b = 8'h02;
            8'h65: b = (v == CV_430HX) ? 8'h02 : 8'h00;
            8'h66: b = (v == CV_430NX || v == CV_430HX) ? 8'h02 : 8'h00;
            8'h67: begin
                unique case (v) inside
                    CV_430NX, CV_430HX: b = 8'h02;
                    CV_430VX:           b = 8'h11;
                    default:            b = 8'h00;
                endcase
            end
            8'h68: b = (v == CV_430HX) ? 8'h11 : 8'h00;
            8'h69: b = (v == CV_430VX) ? 8'h03 : 8'h00;
            8'h70: b = (v == CV_430VX) ? 8'h20 : 8'h00;
            8'h72: b = (v >= CV_430FX) ? 8'h02 : 8'h00;
            8'h74: b = (v == CV_430VX) ? 8'h0e : 8'h00;
            8'h78: b = (v == CV_430VX) ? 8'h23 : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/hbcs_req_if.sv
// request channel: one configuration byte access
interface hbcs_req_if;
    import hbcs_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [FUNC_W-1:0]  function_number;
    logic [OFF_W-1:0]   reg_offset;
    logic [BYTE_W-1:0]  write_data;

    modport source (output valid, mode, function_number, reg_offset, write_data, input ready);
    modport sink   (input valid, mode, function_number, reg_offset, write_data, output ready);
endinterface

### sv/hbcs_rsp_if.sv
// response channel: read byte and the decoded bridge controls
interface hbcs_rsp_if;
    import hbcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_data;
    logic                ext_cache_enable;
    logic                shadow_bios;
    logic [REGION_N-1:0] pam_read_internal;
    logic [REGION_N-1:0] pam_write_internal;
    logic                smram_open;

    modport source (output valid, read_data, ext_cache_enable, shadow_bios,
                    pam_read_internal, pam_write_internal, smram_open, input ready);
    modport sink   (input valid, read_data, ext_cache_enable, shadow_bios,
                    pam_read_internal, pam_write_internal, smram_open, output ready);
endinterface

### sv/hbcs_cfg_if.sv
// configuration write channel: chip variant select
interface hbcs_cfg_if;
    import hbcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAR_W-1:0]  chip_variant;

    modport source (output valid, chip_variant, input ready);
    modport sink   (input valid, chip_variant, output ready);
endinterface

### sv/hbcs_store.sv
// byte store with per-entry valid bits, variant register and the request stage
module hbcs_store #(
    parameter int P_REG_BYTES = hbcs_pkg::REG_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hbcs_pkg::VAR_W-1:0]   i_cfg_variant,
    input  logic                         i_acc,
    input  hbcs_pkg::t_req               i_req,
    input  logic                         i_move,
    input  hbcs_pkg::t_wb                i_wb,
    output logic                         o_s1_v,
    output hbcs_pkg::t_stage             o_stage,
    output logic [hbcs_pkg::VAR_W-1:0]   o_variant
);
    import hbcs_pkg::*;

    localparam int AW = $clog2(P_REG_BYTES);

    logic [BYTE_W-1:0]      r_mem [P_REG_BYTES];
    logic [P_REG_BYTES-1:0] r_valid;
    logic [VAR_W-1:0]       r_variant;
    logic                   r_s1_v;
    t_req                   r_req;
    logic [BYTE_W-1:0]      r_rdata;
    logic                   r_vbit;
    logic                   r_fwd_hit;
    logic [BYTE_W-1:0]      r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wb.en) begin
            r_mem[i_wb.addr[AW-1:0]] <= i_wb.data;
        end
        if (i_acc) begin
            r_rdata <= r_mem[i_req.reg_offset[AW-1:0]];
        end
    end

    // an entry never written since reset or the last variant write reads as the variant default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[i_wb.addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= CV_RESET;
        end else if (i_cfg_we) begin
            r_variant <= (i_cfg_variant > CV_430VX) ? CV_430VX : i_cfg_variant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_acc) begin
            r_s1_v <= 1'b1;
        end else if (i_move) begin
            r_s1_v <= 1'b0;
        end
    end

    // the request ahead writes at the same edge, so its byte is forwarded
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_req      <= i_req;
            r_vbit     <= r_valid[i_req.reg_offset[AW-1:0]];
            r_fwd_hit  <= i_wb.en && (i_wb.addr == i_req.reg_offset);
            r_fwd_data <= i_wb.data;
        end
    end

    always_comb begin
        o_stage.req = r_req;
        if (r_fwd_hit) begin
            o_stage.old_byte = r_fwd_data;
        end else if (r_vbit) begin
            o_stage.old_byte = r_rdata;
        end else begin
            o_stage.old_byte = default_byte(r_variant, r_req.reg_offset);
        end
    end

    assign o_s1_v    = r_s1_v;
    assign o_variant = r_variant;

endmodule

### sv/hbcs_update.sv
// write filtering, shadow and smram attribute state, and the response register
module hbcs_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hbcs_pkg::VAR_W-1:0]   i_variant,
    input  logic                         i_s1_v,
    input  hbcs_pkg::t_stage             i_stage,
    input  logic                         i_rsp_ready,
    output logic                         o_move,
    output hbcs_pkg::t_wb                o_wb,
    output logic                         o_rsp_v,
    output hbcs_pkg::t_rsp               o_rsp
);
    import hbcs_pkg::*;

    logic                 r_out_v;
    logic [BYTE_W-1:0]    r_rd;
    logic                 r_cache;
    logic                 r_bios;
    logic [REGION_N-1:0]  r_rd_dram;
    logic [REGION_N-1:0]  r_wr_dram;
    logic                 r_smram;

    logic                 n_cache;
    logic                 n_bios;
    logic [REGION_N-1:0]  n_rd_dram;
    logic [REGION_N-1:0]  n_wr_dram;
    logic                 n_smram;
    logic [BYTE_W-1:0]    n_rd;

    logic                 do_wr;
    logic                 ro;
    logic [BYTE_W-1:0]    val;
    logic [BYTE_W-1:0]    diff;
    logic [OFF_W-1:0]     off;
    logic [BYTE_W-1:0]    data;

    assign o_move = i_s1_v && (!r_out_v || i_rsp_ready);
    assign off    = i_stage.req.reg_offset;
    assign data   = i_stage.req.write_data;
    assign do_wr  = (i_stage.req.mode == MODE_WRITE) && (i_stage.req.function_number == '0);
    assign diff   = i_stage.old_byte ^ data;

    always_comb begin
        val = data;
        ro  = 1'b0;
        unique case (off) inside
            OFF_VID_LO, OFF_VID_HI, OFF_DID_LO, OFF_DID_HI, OFF_REV,
            OFF_CLS_0, OFF_CLS_1, OFF_CLS_2, OFF_CLS_3, OFF_HDR,
            [OFF_RO_LO:OFF_RO_HI]: ro = 1'b1;
            OFF_CMD_LO: begin
                if (i_variant >= CV_430FX) begin
                    val = data & ((i_variant == CV_430FX_BRD) ? MASK_CMD_FXB : MASK_CMD_FX);
                end else begin
                    val = data & MASK_CMD_TX;
                end
                val = val | CMD_FORCE;
            end
            OFF_CMD_HI: val = (i_variant >= CV_430FX) ? '0 : (data & MASK_CMD_HI);
            OFF_STS_LO: val = '0;
            OFF_STS_HI: begin
                if (i_variant >= CV_430HX) begin
                    val = (data & MASK_STS_KEEP) | STS_BASE;
                end else begin
                    val = (i_variant == CV_430FX_BRD) ? STS_FXB : STS_BASE;
                end
            end
            default: ;
        endcase
    end

    assign o_wb.en   = o_move && do_wr && !ro;
    assign o_wb.addr = off;
    assign o_wb.data = val;

    always_comb begin
        n_cache   = r_cache;
        n_bios    = r_bios;
        n_rd_dram = r_rd_dram;
        n_wr_dram = r_wr_dram;
        n_smram   = r_smram;
        if (do_wr) begin
            if (off == OFF_CACHE) begin
                n_cache = data[0];
            end
            // a region changes only when its nibble changes
            if (off == OFF_PAM0 && diff[7:4] != '0) begin
                n_rd_dram[0] = data[4];
                n_wr_dram[0] = data[5];
                n_bios       = data[4];
            end
            for (int i = 0; i < PAM_HI_N; i++) begin
                if (off == OFF_PAM1 + OFF_W'(i)) begin
                    if (diff[3:0] != '0) begin
                        n_rd_dram[2*i+1] = data[0];
                        n_wr_dram[2*i+1] = data[1];
                    end
                    if (diff[7:4] != '0) begin
                        n_rd_dram[2*i+2] = data[4];
                        n_wr_dram[2*i+2] = data[5];
                    end
                end
            end
            if (off == OFF_SMRAM) begin
                if (i_variant >= CV_430FX) begin
                    if ((diff & MASK_SMM_FX) != '0) begin
                        n_smram = ((data & MASK_SMM_FX) == MASK_SMM_FX);
                    end
                end else if ((diff & MASK_SMM_TX) != '0) begin
                    n_smram = data[5];
                end
            end
        end
    end

    always_comb begin
        if (i_stage.req.mode == MODE_READ) begin
            n_rd = (i_stage.req.function_number != '0) ? FUNC_ABSENT : i_stage.old_byte;
        end else begin
            n_rd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cache   <= 1'b0;
            r_bios    <= 1'b0;
            r_rd_dram <= '0;
            r_wr_dram <= '0;
            r_smram   <= 1'b0;
        end else if (o_move) begin
            r_cache   <= n_cache;
            r_bios    <= n_bios;
            r_rd_dram <= n_rd_dram;
            r_wr_dram <= n_wr_dram;
            r_smram   <= n_smram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_move) begin
            r_out_v <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_rd <= n_rd;
        end
    end

    // flags only move with a request (or clear on reset or a variant write), so they stay matched to the held response
    assign o_rsp_v                  = r_out_v;
    assign o_rsp.read_data          = r_rd;
    assign o_rsp.ext_cache_enable   = r_cache;
    assign o_rsp.shadow_bios        = r_bios;
    assign o_rsp.pam_read_internal  = r_rd_dram;
    assign o_rsp.pam_write_internal = r_wr_dram;
    assign o_rsp.smram_open         = r_smram;

endmodule

### sv/host_bridge_config_space.sv
// Host-bridge PCI configuration space for seven chip variants. Takes one byte read or write
// per cycle as long as the response side keeps up: a request passes one request stage with
// the registered byte-store read, then the response register. The 256-byte store is one
// memory with a write port and a registered read port; a per-byte valid bit makes a
// never-written byte read as the variant default, so reset and a variant write take effect
// at once with no clearing pass. A variant write must be issued only while no request is
// outstanding.
module host_bridge_config_space #(
    parameter int P_REG_BYTES = hbcs_pkg::REG_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbcs_cfg_if.sink   i_cfg,
    hbcs_req_if.sink   i_req,
    hbcs_rsp_if.source o_rsp
);
    import hbcs_pkg::*;

    logic              cfg_we;
    logic              acc;
    logic              move;
    logic              s1_v;
    logic              rsp_v;
    logic [VAR_W-1:0]  variant;
    t_req              req;
    t_stage            stage;
    t_wb               wb;
    t_rsp              rsp;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    assign i_req.ready = !s1_v || move;
    assign acc         = i_req.valid && i_req.ready;

    assign req.mode            = i_req.mode;
    assign req.function_number = i_req.function_number;
    assign req.reg_offset      = i_req.reg_offset;
    assign req.write_data      = i_req.write_data;

    hbcs_store #(
        .P_REG_BYTES (P_REG_BYTES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_variant (i_cfg.chip_variant),
        .i_acc         (acc),
        .i_req         (req),
        .i_move        (move),
        .i_wb          (wb),
        .o_s1_v        (s1_v),
        .o_stage       (stage),
        .o_variant     (variant)
    );

    hbcs_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_variant   (variant),
        .i_s1_v      (s1_v),
        .i_stage     (stage),
        .i_rsp_ready (o_rsp.ready),
        .o_move      (move),
        .o_wb        (wb),
        .o_rsp_v     (rsp_v),
        .o_rsp       (rsp)
    );

    assign o_rsp.valid              = rsp_v;
    assign o_rsp.read_data          = rsp.read_data;
    assign o_rsp.ext_cache_enable   = rsp.ext_cache_enable;
    assign o_rsp.shadow_bios        = rsp.shadow_bios;
    assign o_rsp.pam_read_internal  = rsp.pam_read_internal;
    assign o_rsp.pam_write_internal = rsp.pam_write_internal;
    assign o_rsp.smram_open         = rsp.smram_open;

endmodule
